// ===== src/ec_hce_pkg.sv =====
// Shared types, constants and helpers of the ACPI EC host command engine.
// Depends on nothing; every other file of the block refers to it by scoped names.
package ec_hce_pkg;

    // Request buffer depth in bytes, and size of the EC byte RAM
    localparam int REQ_BUF_DEPTH = 16;
    localparam int RAM_BYTES     = 256;
    localparam int RAM_AW        = (RAM_BYTES > 1) ? $clog2(RAM_BYTES) : 1;
    localparam int CNT_W         = 5;

    // ACPI EC command codes
    localparam logic [7:0] CODE_NONE  = 8'h00;
    localparam logic [7:0] CODE_READ  = 8'h80;
    localparam logic [7:0] CODE_WRITE = 8'h81;
    localparam logic [7:0] CODE_QUERY = 8'h84;

    // Configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ACPI_MODE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SCI_EN    = 8'd1;
    localparam int CFG_DATA_W = 8;

    typedef struct packed {
        logic       mode;
        logic [7:0] port_byte;
        logic       system_in_s0;
    } in_item_t;

    typedef struct packed {
        logic       response_valid;
        logic [7:0] response_byte;
        logic       sci_pulse;
        logic       overflow;
    } out_item_t;

    typedef struct packed {
        logic acpi_mode_on;
        logic sci_enable;
    } cfg_t;

    // One RAM access travelling behind an assembled request
    typedef struct packed {
        logic       rd;
        logic       wr;
        logic [7:0] addr;
        logic [7:0] wdata;
    } ram_req_t;

    // Request after assembly, waiting for its RAM access
    typedef struct packed {
        ram_req_t ram;
        logic     rsp_valid;
        logic     sci;
        logic     ovf;
    } stage_t;

    // Bytes after the command byte that complete a command
    function automatic logic [CNT_W-1:0] needed_bytes(input logic [7:0] code);
        logic [CNT_W-1:0] n;
        n = '0;
        if (code == CODE_READ) begin
            n = CNT_W'(1);
        end else if (code == CODE_WRITE) begin
            n = CNT_W'(2);
        end
        return n;
    endfunction

endpackage

// ===== src/ec_hce_ram.sv =====
// EC byte RAM: one synchronous port, registered read data, valid bits per entry.
// Depends on ec_hce_pkg for the RAM size and the access struct.
module ec_hce_ram (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  ec_hce_pkg::ram_req_t req,
    output logic [7:0]           rdata
);

    logic [7:0]                      mem [ec_hce_pkg::RAM_BYTES];
    logic [ec_hce_pkg::RAM_BYTES-1:0] valid_reg;
    logic [7:0]                      rdata_reg;
    logic                            in_range;
    logic [ec_hce_pkg::RAM_AW-1:0]   idx;

    assign in_range = ({1'b0, req.addr} < 9'(ec_hce_pkg::RAM_BYTES));
    assign idx      = req.addr[ec_hce_pkg::RAM_AW-1:0];

    // Store write data; indexes beyond the RAM are ignored
    always_ff @(posedge aclk) begin
        if (en && req.wr && in_range) begin
            mem[idx] <= req.wdata;
        end
    end

    // Mark entries written since reset; an unmarked entry reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en && req.wr && in_range) begin
            valid_reg[idx] <= 1'b1;
        end
    end

    // Register read data; hold it while the result waits
    always_ff @(posedge aclk) begin
        if (en && req.rd) begin
            rdata_reg <= (in_range && valid_reg[idx]) ? mem[idx] : 8'h00;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ec_hce_ctrl.sv =====
// Request assembler: command state, byte count and held index, plus the stage
// register that carries each assembled request to the RAM. Depends on ec_hce_pkg.
module ec_hce_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ec_hce_pkg::cfg_t     cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ec_hce_pkg::in_item_t s_data,
    input  logic                 advance,
    output logic                 stg_valid,
    output ec_hce_pkg::stage_t   stg
);

    logic [7:0]                   act_reg, act_next, act1;
    logic [ec_hce_pkg::CNT_W-1:0] cnt_reg, cnt_next, cnt1;
    logic [7:0]                   held_reg, held_next, held1;
    logic                         stg_valid_reg;
    ec_hce_pkg::stage_t           stg_reg, stg_next;
    logic                         accept;
    logic                         ovf, pend, done;

    // Take a new request whenever the stage is empty or drains this cycle
    assign s_ready = !stg_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    // Assemble the request against the current command state
    always_comb begin
        ovf  = !s_data.mode && (cnt_reg >= ec_hce_pkg::CNT_W'(ec_hce_pkg::REQ_BUF_DEPTH));
        act1 = act_reg;
        cnt1 = cnt_reg;
        held1 = held_reg;
        if (s_data.mode) begin
            act1 = s_data.port_byte;
            cnt1 = '0;
        end else begin
            if (cnt_reg == '0) begin
                act1 = s_data.port_byte;
            end
            if (cnt_reg == ec_hce_pkg::CNT_W'(1)) begin
                held1 = s_data.port_byte;
            end
        end

        pend = (act1 != ec_hce_pkg::CODE_NONE);
        done = pend && (ec_hce_pkg::needed_bytes(act1) == cnt1);

        stg_next.ram.rd    = !ovf && done && (act1 == ec_hce_pkg::CODE_READ);
        stg_next.ram.wr    = !ovf && done && (act1 == ec_hce_pkg::CODE_WRITE);
        stg_next.ram.addr  = held1;
        stg_next.ram.wdata = s_data.port_byte;
        stg_next.rsp_valid = !ovf && done &&
                             ((act1 == ec_hce_pkg::CODE_READ) ||
                              (act1 == ec_hce_pkg::CODE_QUERY));
        stg_next.sci       = !ovf && pend &&
                             ((act1 == ec_hce_pkg::CODE_READ) ||
                              (act1 == ec_hce_pkg::CODE_WRITE)) &&
                             cfg.sci_enable && cfg.acpi_mode_on && s_data.system_in_s0;
        stg_next.ovf       = ovf;

        // Dropped bytes leave the state untouched
        act_next  = act_reg;
        cnt_next  = cnt_reg;
        held_next = held_reg;
        if (accept && !ovf) begin
            act_next  = done ? ec_hce_pkg::CODE_NONE : act1;
            cnt_next  = cnt1 + ec_hce_pkg::CNT_W'(1);
            held_next = held1;
        end
    end

    // Hold command state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg  <= ec_hce_pkg::CODE_NONE;
            cnt_reg  <= '0;
            held_reg <= 8'h00;
        end else begin
            act_reg  <= act_next;
            cnt_reg  <= cnt_next;
            held_reg <= held_next;
        end
    end

    // Advance the stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
        end else if (s_ready) begin
            stg_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stg_reg <= stg_next;
        end
    end

    assign stg_valid = stg_valid_reg;
    assign stg       = stg_reg;

endmodule

// ===== src/acpi_ec_host_command_engine_top.sv =====
// Top level of the ACPI EC host command engine: configuration registers,
// result stage and wiring. Depends on ec_hce_pkg, ec_hce_ctrl and ec_hce_ram.
//
// Usage:
//   s_valid/s_ready/s_data carry host port bytes (command or data, with the
//   S0 flag). m_valid/m_ready/m_data return exactly one result per request:
//   response byte and its valid flag, SCI pulse flag and overflow flag.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write register 0 (ACPI mode) or
//   1 (SCI enable); bit 0 of the data is kept, other indexes are ignored.
//   cfg_ready is always high; write only while no request is in flight.
// Path: an accepted request is registered in the assemble stage, then passes
//   the RAM access with registered read data into the result register on m_*.
// Throughput: one request per cycle while m_ready stays high, set by the
//   single RAM port, which does at most one read or one write per request.
// Reset: aresetn (synchronous, active low) clears command state, empties the
//   pipeline, sets both configuration bits and marks every RAM byte as zero
//   through per-entry valid bits, so no clearing pass is needed.
// Stall: while m_ready is low the result holds; one more request is taken
//   into the assemble stage, then s_ready drops until the result drains.
module acpi_ec_host_command_engine_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ec_hce_pkg::in_item_t                s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ec_hce_pkg::out_item_t               m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ec_hce_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ec_hce_pkg::CFG_DATA_W-1:0]   cfg_data
);

    ec_hce_pkg::cfg_t   cfg_reg;
    ec_hce_pkg::stage_t stg;
    logic               stg_valid;
    logic               advance;
    logic               res_valid_reg;
    logic               res_rsp_reg, res_rd_reg, res_sci_reg, res_ovf_reg;
    logic [7:0]         rdata;

    assign cfg_ready = 1'b1;

    // Hold configuration bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.acpi_mode_on <= 1'b1;
            cfg_reg.sci_enable   <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                ec_hce_pkg::CFG_IDX_ACPI_MODE: cfg_reg.acpi_mode_on <= cfg_data[0];
                ec_hce_pkg::CFG_IDX_SCI_EN:    cfg_reg.sci_enable   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    ec_hce_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .advance   (advance),
        .stg_valid (stg_valid),
        .stg       (stg)
    );

    // Move the assembled request on when the result slot is free
    assign advance = stg_valid && (!res_valid_reg || m_ready);

    ec_hce_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .req     (stg.ram),
        .rdata   (rdata)
    );

    // Hold the result until the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (!res_valid_reg || m_ready) begin
            res_valid_reg <= stg_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_rsp_reg <= stg.rsp_valid;
            res_rd_reg  <= stg.ram.rd;
            res_sci_reg <= stg.sci;
            res_ovf_reg <= stg.ovf;
        end
    end

    assign m_valid                = res_valid_reg;
    assign m_data.response_valid  = res_rsp_reg;
    assign m_data.response_byte   = res_rd_reg ? rdata : 8'h00;
    assign m_data.sci_pulse       = res_sci_reg;
    assign m_data.overflow        = res_ovf_reg;

endmodule
